FILE: hdl/slcfr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package slcfr_pkg;

    // field widths
    localparam int BYTE_W    = 8;
    localparam int LEN_W     = 7;
    localparam int CRC_W     = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 8;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SYNC_FIRST  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SYNC_SECOND = 2'd1;

    // register reset values
    localparam logic [BYTE_W-1:0] SYNC_FIRST_RST  = 8'hEB;
    localparam logic [BYTE_W-1:0] SYNC_SECOND_RST = 8'h90;

    // crc-16/ccitt-false constants
    localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;
    localparam logic [CRC_W-1:0] CRC_POLY = 16'h1021;

    // commands from controller to datapath, already qualified by the beat
    typedef struct packed {
        logic crc_init;
        logic take_id;
        logic take_len;
        logic store_byte;
        logic take_crc_hi;
        logic emit_start;
        logic rd_issue;
        logic emit_next;
    } cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic first_hit;
        logic second_hit;
        logic len_over;
        logic len_zero;
        logic pay_done;
        logic crc_ok;
        logic emit_last;
    } sts_t;

    // one result beat
    typedef struct packed {
        logic [BYTE_W-1:0] frame_id;
        logic [LEN_W-1:0]  frame_length;
        logic [BYTE_W-1:0] data_byte;
        logic              data_present;
        logic              last;
    } frame_t;

    // one byte through the crc, msb first
    function automatic logic [CRC_W-1:0] crc_feed(input logic [CRC_W-1:0] crc_in,
                                                  input logic [BYTE_W-1:0] b);
        logic [CRC_W-1:0] c;
        c = crc_in ^ {b, 8'h00};
        for (int k = 0; k < 8; k++)
        begin
            if (c[CRC_W-1])
                c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[CRC_W-2:0], 1'b0};
        end
        return c;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/slcfr_rx_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface slcfr_rx_if;
    logic                            valid;
    logic                            ready;
    logic [slcfr_pkg::BYTE_W-1:0]    rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

FILE: hdl/slcfr_frame_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface slcfr_frame_if;
    logic                            valid;
    logic                            ready;
    logic [slcfr_pkg::BYTE_W-1:0]    frame_id;
    logic [slcfr_pkg::LEN_W-1:0]     frame_length;
    logic [slcfr_pkg::BYTE_W-1:0]    data_byte;
    logic                            data_present;
    logic                            last;

    modport source (output valid, output frame_id, output frame_length, output data_byte,
                    output data_present, output last, input ready);
    modport sink   (input valid, input frame_id, input frame_length, input data_byte,
                    input data_present, input last, output ready);
endinterface

`default_nettype wire

FILE: hdl/slcfr_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module slcfr_datapath #(
    parameter int MAX_PAYLOAD = 64
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_we,
    input  wire logic [slcfr_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [slcfr_pkg::CFG_DAT_W-1:0]     cfg_data,
    input  wire logic [slcfr_pkg::BYTE_W-1:0]        rx_byte,
    input  wire slcfr_pkg::cmd_t                     cmd,
    output      slcfr_pkg::sts_t                     sts,
    output      slcfr_pkg::frame_t                   frame_out
);

    localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam logic [slcfr_pkg::BYTE_W-1:0] MAX_B  = 8'(MAX_PAYLOAD);
    localparam logic [slcfr_pkg::LEN_W-1:0]  ONE_L  = 7'd1;

    logic [slcfr_pkg::BYTE_W-1:0] sync_first_reg, sync_second_reg;
    logic [slcfr_pkg::BYTE_W-1:0] id_reg, id_next;
    logic [slcfr_pkg::LEN_W-1:0]  len_reg, len_next;
    logic [slcfr_pkg::LEN_W-1:0]  idx_reg, idx_next;
    logic [slcfr_pkg::LEN_W-1:0]  rd_idx_reg, rd_idx_next;
    logic [slcfr_pkg::CRC_W-1:0]  crc_reg, crc_next;
    logic [slcfr_pkg::BYTE_W-1:0] crc_hi_reg, crc_hi_next;
    logic [slcfr_pkg::BYTE_W-1:0] rdata_reg;
    logic [slcfr_pkg::BYTE_W-1:0] mem [MAX_PAYLOAD];
    logic [slcfr_pkg::CRC_W-1:0]  crc_fed;
    logic                         empty;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_first_reg  <= slcfr_pkg::SYNC_FIRST_RST;
            sync_second_reg <= slcfr_pkg::SYNC_SECOND_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                slcfr_pkg::REG_SYNC_FIRST:  sync_first_reg  <= cfg_data;
                slcfr_pkg::REG_SYNC_SECOND: sync_second_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign crc_fed = slcfr_pkg::crc_feed(crc_reg, rx_byte);

    // frame header, counters and crc
    always_comb
    begin
        id_next     = id_reg;
        len_next    = len_reg;
        idx_next    = idx_reg;
        rd_idx_next = rd_idx_reg;
        crc_next    = crc_reg;
        crc_hi_next = crc_hi_reg;
        if (cmd.crc_init)
            crc_next = slcfr_pkg::CRC_INIT;
        if (cmd.take_id)
        begin
            id_next  = rx_byte;
            crc_next = crc_fed;
        end
        if (cmd.take_len)
        begin
            idx_next = '0;
            if (!sts.len_over)
            begin
                len_next = rx_byte[slcfr_pkg::LEN_W-1:0];
                crc_next = crc_fed;
            end
        end
        if (cmd.store_byte)
        begin
            crc_next = crc_fed;
            idx_next = idx_reg + ONE_L;
        end
        if (cmd.take_crc_hi)
            crc_hi_next = rx_byte;
        if (cmd.emit_start)
            rd_idx_next = '0;
        if (cmd.emit_next)
            rd_idx_next = rd_idx_reg + ONE_L;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            id_reg     <= '0;
            len_reg    <= '0;
            idx_reg    <= '0;
            rd_idx_reg <= '0;
            crc_reg    <= slcfr_pkg::CRC_INIT;
            crc_hi_reg <= '0;
        end
        else
        begin
            id_reg     <= id_next;
            len_reg    <= len_next;
            idx_reg    <= idx_next;
            rd_idx_reg <= rd_idx_next;
            crc_reg    <= crc_next;
            crc_hi_reg <= crc_hi_next;
        end
    end

    // payload store, one write and one registered read
    always_ff @(posedge clk)
    begin
        if (cmd.store_byte)
            mem[idx_reg[AW-1:0]] <= rx_byte;
        if (cmd.rd_issue)
            rdata_reg <= mem[rd_idx_reg[AW-1:0]];
    end

    assign empty = (len_reg == '0);

    // status toward the controller
    always_comb
    begin
        sts.first_hit  = (rx_byte == sync_first_reg);
        sts.second_hit = (rx_byte == sync_second_reg);
        sts.len_over   = (rx_byte > MAX_B);
        sts.len_zero   = (rx_byte == '0);
        sts.pay_done   = ((idx_reg + ONE_L) >= len_reg);
        sts.crc_ok     = ({crc_hi_reg, rx_byte} == crc_reg);
        sts.emit_last  = empty || ((rd_idx_reg + ONE_L) == len_reg);
    end

    // result beat
    always_comb
    begin
        frame_out.frame_id     = id_reg;
        frame_out.frame_length = len_reg;
        frame_out.data_byte    = empty ? '0 : rdata_reg;
        frame_out.data_present = !empty;
        frame_out.last         = sts.emit_last;
    end

endmodule

`default_nettype wire

FILE: hdl/slcfr_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module slcfr_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              rx_valid,
    output      logic              rx_ready,
    output      logic              out_valid,
    input  wire logic              out_ready,
    input  wire slcfr_pkg::sts_t   sts,
    output      slcfr_pkg::cmd_t   cmd
);

    typedef enum logic [8:0] {
        ST_HUNT1   = 9'b000000001,
        ST_HUNT2   = 9'b000000010,
        ST_ID      = 9'b000000100,
        ST_LEN     = 9'b000001000,
        ST_PAYLOAD = 9'b000010000,
        ST_CRCHI   = 9'b000100000,
        ST_CRCLO   = 9'b001000000,
        ST_RD      = 9'b010000000,
        ST_SHOW    = 9'b100000000
    } state_t;

    state_t state_reg, state_next;
    logic   rx_fire;
    logic   out_fire;

    assign rx_ready  = (state_reg != ST_RD) && (state_reg != ST_SHOW);
    assign out_valid = (state_reg == ST_SHOW);
    assign rx_fire   = rx_valid && rx_ready;
    assign out_fire  = out_valid && out_ready;

    // next state and datapath commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_HUNT1:
            begin
                if (rx_fire && sts.first_hit)
                    state_next = ST_HUNT2;
            end
            ST_HUNT2:
            begin
                if (rx_fire)
                begin
                    if (sts.second_hit)
                    begin
                        cmd.crc_init = 1'b1;
                        state_next   = ST_ID;
                    end
                    else
                        state_next = ST_HUNT1;
                end
            end
            ST_ID:
            begin
                if (rx_fire)
                begin
                    cmd.take_id = 1'b1;
                    state_next  = ST_LEN;
                end
            end
            ST_LEN:
            begin
                if (rx_fire)
                begin
                    cmd.take_len = 1'b1;
                    if (sts.len_over)
                        state_next = ST_HUNT1;
                    else if (sts.len_zero)
                        state_next = ST_CRCHI;
                    else
                        state_next = ST_PAYLOAD;
                end
            end
            ST_PAYLOAD:
            begin
                if (rx_fire)
                begin
                    cmd.store_byte = 1'b1;
                    if (sts.pay_done)
                        state_next = ST_CRCHI;
                end
            end
            ST_CRCHI:
            begin
                if (rx_fire)
                begin
                    cmd.take_crc_hi = 1'b1;
                    state_next      = ST_CRCLO;
                end
            end
            ST_CRCLO:
            begin
                if (rx_fire)
                begin
                    if (sts.crc_ok)
                    begin
                        cmd.emit_start = 1'b1;
                        state_next     = ST_RD;
                    end
                    else
                        state_next = ST_HUNT1;
                end
            end
            ST_RD:
            begin
                cmd.rd_issue = 1'b1;
                state_next   = ST_SHOW;
            end
            ST_SHOW:
            begin
                if (out_fire)
                begin
                    if (sts.emit_last)
                        state_next = ST_HUNT1;
                    else
                    begin
                        cmd.emit_next = 1'b1;
                        state_next    = ST_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_HUNT1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_HUNT1;
        else
            state_reg <= state_next;
    end

    // input and output sides never open together
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(rx_ready && out_valid))
        else $error("input accepted while a result is shown");

    // a memory read is always followed by its result beat
    a_read_then_show: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RD) |=> (state_reg == ST_SHOW))
        else $error("result beat did not follow memory read");

    // emission only starts on a matching crc
    a_emit_on_crc: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_start |-> (rx_fire && sts.crc_ok))
        else $error("frame emitted without crc match");

    // final beat of a frame returns to the hunt
    a_last_to_hunt: assert property (@(posedge clk) disable iff (!rst_n)
        (out_fire && sts.emit_last) |=> (state_reg == ST_HUNT1))
        else $error("no return to hunt after final beat");

endmodule

`default_nettype wire

FILE: hdl/sync_len_crc_frame_receiver_top.sv
// first beat: after the crc low byte is accepted, ST_RD reads the payload memory, then
//   ST_SHOW presents the first result beat; throughput: one received byte per cycle
//   while a frame comes in; while a frame goes out, each result beat takes a memory
//   read (ST_RD), then waits in ST_SHOW for frame ready, and no byte is accepted
// reset: asynchronous active low; back to the sync hunt, sync bytes 0xEB and 0x90,
//   crc 0xFFFF; the payload memory is not cleared
`timescale 1ns / 1ps
`default_nettype none

module sync_len_crc_frame_receiver_top #(
    parameter int MAX_PAYLOAD = 64
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [slcfr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [slcfr_pkg::CFG_DAT_W-1:0]   cfg_data,
    slcfr_rx_if.sink                               rx,
    slcfr_frame_if.source                          frame
);

    slcfr_pkg::cmd_t   cmd;
    slcfr_pkg::sts_t   sts;
    slcfr_pkg::frame_t frame_out;

    // controller
    slcfr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .rx_valid  (rx.valid),
        .rx_ready  (rx.ready),
        .out_valid (frame.valid),
        .out_ready (frame.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // datapath
    slcfr_datapath #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .rx_byte   (rx.rx_byte),
        .cmd       (cmd),
        .sts       (sts),
        .frame_out (frame_out)
    );

    // result beat onto the output channel
    assign frame.frame_id     = frame_out.frame_id;
    assign frame.frame_length = frame_out.frame_length;
    assign frame.data_byte    = frame_out.data_byte;
    assign frame.data_present = frame_out.data_present;
    assign frame.last         = frame_out.last;

endmodule

`default_nettype wire

FILE: dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam int BYTE_W    = slcfr_pkg::BYTE_W;
    localparam int LEN_W     = slcfr_pkg::LEN_W;
    localparam int CRC_W     = slcfr_pkg::CRC_W;
    localparam int CFG_IDX_W = slcfr_pkg::CFG_IDX_W;
    localparam int CFG_DAT_W = slcfr_pkg::CFG_DAT_W;

    localparam logic [CRC_W-1:0]     CRC_INIT        = slcfr_pkg::CRC_INIT;
    localparam logic [CRC_W-1:0]     CRC_POLY        = slcfr_pkg::CRC_POLY;
    localparam logic [CFG_IDX_W-1:0] REG_SYNC_FIRST  = slcfr_pkg::REG_SYNC_FIRST;
    localparam logic [CFG_IDX_W-1:0] REG_SYNC_SECOND = slcfr_pkg::REG_SYNC_SECOND;
    localparam logic [BYTE_W-1:0]    SYNC_FIRST_RST  = slcfr_pkg::SYNC_FIRST_RST;
    localparam logic [BYTE_W-1:0]    SYNC_SECOND_RST = slcfr_pkg::SYNC_SECOND_RST;

    localparam int MAX_PAY     = 64;
    localparam int HOLD_CYCLES = 400;
    localparam int STALL_LIMIT = 3000;
    localparam int SETTLE      = 16;
    localparam int PHASE_BYTES = 62;

    // receive side states, tracked beside the block
    typedef enum logic [2:0] {
        HUNT_FIRST,
        HUNT_SECOND,
        TAKE_ID,
        TAKE_LEN,
        TAKE_PAYLOAD,
        TAKE_CRC_HI,
        TAKE_CRC_LO
    } deframe_state_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DAT_W-1:0] cfg_data;

    slcfr_rx_if    rx_bus ();
    slcfr_frame_if frame_bus ();

    sync_len_crc_frame_receiver_top #(
        .MAX_PAYLOAD (MAX_PAY)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .rx        (rx_bus),
        .frame     (frame_bus)
    );

    // stimulus bytes waiting to go in, frame beats waiting to come out
    logic [BYTE_W-1:0] rx_stream_q [$];
    slcfr_pkg::frame_t frame_beats_q [$];

    // idling knobs, set per phase
    int send_idle_pct;
    int recv_stall_pct;
    logic long_hold_req;
    logic long_hold_done;
    int   hold_left;

    int error_count;
    int stall_cycles;
    int phase_sent;

    // tracked copy of the configuration and the deframer state
    logic [BYTE_W-1:0] sync_first_v;
    logic [BYTE_W-1:0] sync_second_v;
    deframe_state_t    dstate;
    logic [BYTE_W-1:0] held_id_v;
    logic [LEN_W-1:0]  held_len_v;
    logic [LEN_W-1:0]  pay_idx;
    logic [BYTE_W-1:0] pay_mem [0:MAX_PAY-1];
    logic [CRC_W-1:0]  run_crc;
    logic [BYTE_W-1:0] crc_hi_v;

    // crc-16/ccitt-false, one bit at a time, msb first
    function automatic logic [CRC_W-1:0] crc16_ccitt_byte(input logic [CRC_W-1:0] c,
                                                          input logic [BYTE_W-1:0] b);
        logic [CRC_W-1:0] r;
        logic             fb;
        r = c;
        for (int i = BYTE_W - 1; i >= 0; i--)
        begin
            fb = r[CRC_W-1] ^ b[i];
            r  = {r[CRC_W-2:0], 1'b0} ^ (fb ? CRC_POLY : '0);
        end
        return r;
    endfunction

    // advance the tracked deframer by one accepted byte, queue any frame beats
    task automatic deframe_byte(input logic [BYTE_W-1:0] b);
        slcfr_pkg::frame_t beat;
        case (dstate)
            HUNT_FIRST:
                if (b == sync_first_v)
                    dstate = HUNT_SECOND;
            HUNT_SECOND:
                if (b == sync_second_v)
                begin
                    dstate  = TAKE_ID;
                    run_crc = CRC_INIT;
                end
                else
                    dstate = HUNT_FIRST;
            TAKE_ID:
            begin
                held_id_v = b;
                run_crc   = crc16_ccitt_byte(run_crc, b);
                dstate    = TAKE_LEN;
            end
            TAKE_LEN:
            begin
                pay_idx = '0;
                if (b > MAX_PAY)
                    dstate = HUNT_FIRST;
                else
                begin
                    held_len_v = b[LEN_W-1:0];
                    run_crc    = crc16_ccitt_byte(run_crc, b);
                    dstate     = (b == 0) ? TAKE_CRC_HI : TAKE_PAYLOAD;
                end
            end
            TAKE_PAYLOAD:
            begin
                if (pay_idx < MAX_PAY)
                    pay_mem[pay_idx[5:0]] = b;
                run_crc = crc16_ccitt_byte(run_crc, b);
                pay_idx = pay_idx + 1'b1;
                if (pay_idx >= held_len_v || pay_idx >= MAX_PAY)
                    dstate = TAKE_CRC_HI;
            end
            TAKE_CRC_HI:
            begin
                crc_hi_v = b;
                dstate   = TAKE_CRC_LO;
            end
            TAKE_CRC_LO:
            begin
                dstate = HUNT_FIRST;
                if ({crc_hi_v, b} == run_crc)
                begin
                    // empty frame gives a single marker beat
                    if (held_len_v == 0)
                    begin
                        beat.frame_id     = held_id_v;
                        beat.frame_length = '0;
                        beat.data_byte    = '0;
                        beat.data_present = 1'b0;
                        beat.last         = 1'b1;
                        frame_beats_q.push_back(beat);
                    end
                    for (int k = 0; k < held_len_v && k < MAX_PAY; k++)
                    begin
                        beat.frame_id     = held_id_v;
                        beat.frame_length = held_len_v;
                        beat.data_byte    = pay_mem[k];
                        beat.data_present = 1'b1;
                        beat.last         = (k + 1 == held_len_v);
                        frame_beats_q.push_back(beat);
                    end
                end
            end
            default:
                dstate = HUNT_FIRST;
        endcase
    endtask

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // rx driver: hold an offered beat until taken, otherwise maybe idle
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rx_bus.valid && rx_bus.ready)
            begin
                deframe_byte(rx_bus.rx_byte);
                void'(rx_stream_q.pop_front());
            end
            if (rx_bus.valid && !rx_bus.ready)
                ;
            else if (rx_stream_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                rx_bus.valid   <= 1'b1;
                rx_bus.rx_byte <= rx_stream_q[0];
            end
            else
                rx_bus.valid <= 1'b0;
        end
    end

    // compare one field of a frame beat
    task automatic check_field(input string fname, input logic [BYTE_W-1:0] exp_v,
                               input logic [BYTE_W-1:0] act_v);
        if (exp_v !== act_v)
        begin
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, fname, exp_v, act_v);
            error_count++;
        end
    endtask

    // frame monitor and ready control, including the long hold-off
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (frame_bus.valid && frame_bus.ready)
            begin
                if (frame_beats_q.size() == 0)
                begin
                    $display("%0t: unexpected frame beat, expected none, got id 0x%0h len %0d",
                             $time, frame_bus.frame_id, frame_bus.frame_length);
                    error_count++;
                end
                else
                begin
                    check_field("frame_id", frame_beats_q[0].frame_id, frame_bus.frame_id);
                    check_field("frame_length", BYTE_W'(frame_beats_q[0].frame_length),
                                BYTE_W'(frame_bus.frame_length));
                    check_field("data_byte", frame_beats_q[0].data_byte, frame_bus.data_byte);
                    check_field("data_present", BYTE_W'(frame_beats_q[0].data_present),
                                BYTE_W'(frame_bus.data_present));
                    check_field("last", BYTE_W'(frame_beats_q[0].last),
                                BYTE_W'(frame_bus.last));
                    void'(frame_beats_q.pop_front());
                end
            end
            if (long_hold_req && !long_hold_done)
            begin
                long_hold_done  <= 1'b1;
                hold_left       <= HOLD_CYCLES;
                frame_bus.ready <= 1'b0;
            end
            else if (hold_left != 0)
            begin
                hold_left       <= hold_left - 1;
                frame_bus.ready <= 1'b0;
            end
            else
                frame_bus.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // watchdog: no beat moves while work is pending
    always @(posedge clk)
    begin
        if (!rst_n || (rx_stream_q.size() == 0 && frame_beats_q.size() == 0)
            || (rx_bus.valid && rx_bus.ready) || (frame_bus.valid && frame_bus.ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("%0t: watchdog expired with %0d bytes and %0d beats outstanding",
                     $time, rx_stream_q.size(), frame_beats_q.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic push_byte(input logic [BYTE_W-1:0] b);
        rx_stream_q.push_back(b);
        phase_sent++;
    endtask

    // whole frame with the current sync bytes; fill < 0 gives random payload
    task automatic push_frame(input logic [BYTE_W-1:0] id, input int len,
                              input bit corrupt, input int fill = -1);
        logic [CRC_W-1:0]  c;
        logic [BYTE_W-1:0] d;
        push_byte(sync_first_v);
        push_byte(sync_second_v);
        push_byte(id);
        push_byte(BYTE_W'(len));
        c = crc16_ccitt_byte(CRC_INIT, id);
        c = crc16_ccitt_byte(c, BYTE_W'(len));
        for (int k = 0; k < len; k++)
        begin
            d = (fill < 0) ? BYTE_W'($urandom) : BYTE_W'(fill);
            push_byte(d);
            c = crc16_ccitt_byte(c, d);
        end
        if (corrupt)
            c = c ^ (CRC_W'(1) << $urandom_range(0, CRC_W - 1));
        push_byte(c[15:8]);
        push_byte(c[7:0]);
    endtask

    function automatic int pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 4)
            return MAX_PAY;
        else if (r < 14)
            return $urandom_range(9, MAX_PAY - 1);
        return $urandom_range(0, 6);
    endfunction

    // mostly good frames, with bad crcs, broken headers and line noise mixed in
    task automatic gen_traffic(input int n_bytes);
        int               kind;
        logic [BYTE_W-1:0] b;
        phase_sent = 0;
        while (phase_sent < n_bytes)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 65)
                push_frame(BYTE_W'($urandom), pick_len(), 1'b0);
            else if (kind < 75)
                push_frame(BYTE_W'($urandom), $urandom_range(0, 6), 1'b1);
            else if (kind < 82)
            begin
                // length over the limit
                push_byte(sync_first_v);
                push_byte(sync_second_v);
                push_byte(BYTE_W'($urandom));
                push_byte(BYTE_W'($urandom_range(MAX_PAY + 1, 255)));
            end
            else if (kind < 90)
            begin
                // second sync byte wrong
                b = BYTE_W'($urandom);
                while (b == sync_second_v)
                    b = BYTE_W'($urandom);
                push_byte(sync_first_v);
                push_byte(b);
            end
            else
                repeat ($urandom_range(1, 3)) push_byte(BYTE_W'($urandom));
        end
    endtask

    // wait until all bytes are in and all beats are out, then let the block settle
    task automatic drain();
        while (rx_stream_q.size() != 0 || frame_beats_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_sync(input logic [BYTE_W-1:0] first, input logic [BYTE_W-1:0] second);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= REG_SYNC_FIRST;
        cfg_data  <= first;
        @(posedge clk);
        cfg_index <= REG_SYNC_SECOND;
        cfg_data  <= second;
        @(posedge clk);
        cfg_we    <= 1'b0;
        sync_first_v  = first;
        sync_second_v = second;
    endtask

    // stimulus sequence
    initial
    begin
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = '0;
        cfg_data        = '0;
        rx_bus.valid    = 1'b0;
        rx_bus.rx_byte  = '0;
        frame_bus.ready = 1'b0;
        send_idle_pct   = 0;
        recv_stall_pct  = 0;
        long_hold_req   = 1'b0;
        long_hold_done  = 1'b0;
        hold_left       = 0;
        error_count     = 0;
        stall_cycles    = 0;
        sync_first_v    = SYNC_FIRST_RST;
        sync_second_v   = SYNC_SECOND_RST;
        dstate          = HUNT_FIRST;
        held_id_v       = '0;
        held_len_v      = '0;
        pay_idx         = '0;
        run_crc         = CRC_INIT;
        crc_hi_v        = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset sync bytes, empty frame, one byte frame, overlong length,
        // repeated first sync byte, bad crc on an empty frame
        push_frame(8'h00, 0, 1'b0);
        push_frame(8'hFF, 1, 1'b0, 8'hFF);
        push_byte(sync_first_v);
        push_byte(sync_second_v);
        push_byte(8'h41);
        push_byte(BYTE_W'(MAX_PAY + 1));
        push_byte(sync_first_v);
        push_byte(sync_first_v);
        push_byte(sync_second_v);
        push_byte(8'h00);
        push_frame(8'h07, 0, 1'b1);
        drain();

        // extreme sync values, no idling
        write_sync(8'h00, 8'hFF);
        gen_traffic(PHASE_BYTES);
        drain();

        // swapped extremes, sender idles
        write_sync(8'hFF, 8'h00);
        send_idle_pct = 52;
        gen_traffic(PHASE_BYTES);
        drain();

        // random sync bytes, receiver stalls
        write_sync(BYTE_W'($urandom), BYTE_W'($urandom));
        send_idle_pct  = 0;
        recv_stall_pct = 52;
        gen_traffic(PHASE_BYTES);
        drain();

        // back to the reset values, both sides idle
        write_sync(SYNC_FIRST_RST, SYNC_SECOND_RST);
        send_idle_pct  = 31;
        recv_stall_pct = 31;
        gen_traffic(PHASE_BYTES);
        drain();

        // receiver holds off while a full frame and then short frames keep coming so the input backs up
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        long_hold_req  = 1'b1;
        push_frame(BYTE_W'($urandom), MAX_PAY, 1'b0);
        repeat (3) push_frame(BYTE_W'($urandom), $urandom_range(1, 8), 1'b0);
        drain();

        if (frame_beats_q.size() != 0)
        begin
            $display("%0t: %0d frame beats never arrived", $time, frame_beats_q.size());
            error_count++;
        end
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
